FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ON(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// A condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

FILE: src/rrss_pkg.sv
// ----------------------------------------------------------------------------
// rrss_pkg
// Types and constants of the round-robin slice scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rrss_pkg;

    localparam int TASK_W      = 4;
    localparam int TASK_IDS    = 1 << TASK_W;
    localparam int SLICE_W     = 8;
    localparam int COUNT_OUT_W = 5;

    localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd10;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_TICK   = 2'd2,
        REQ_YIELD  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_EMPTY = 2'd1,
        ERR_BAD   = 2'd2
    } t_err;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_APPEND,
        OP_REMOVE,
        OP_ROTATE
    } t_cell_op;

    // Command broadcast to every cell of the queue.
    typedef struct packed {
        t_cell_op            op;
        logic [TASK_W-1:0]   key;
    } t_cell_ctl;

    // Contents of one queue cell as seen by its neighbors.
    typedef struct packed {
        logic                vld;
        logic [TASK_W-1:0]   tsk;
    } t_cell_link;

endpackage

FILE: src/rrss_cell.sv
// ----------------------------------------------------------------------------
// rrss_cell
// One slot of the ready queue. It compares its task with the broadcast key
// and, on a command, takes its neighbor's task or the key.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrss_cell
    import rrss_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_first,
    input  t_cell_ctl  i_ctl,
    input  logic       i_seen,
    input  logic       i_prev_vld,
    input  t_cell_link i_next,
    output t_cell_link o_link,
    output logic       o_seen,
    output logic       o_match
);

    logic              r_vld;
    logic [TASK_W-1:0] r_tsk;
    logic              n_vld;
    logic [TASK_W-1:0] n_tsk;
    logic              seen_incl;

    assign o_match   = r_vld && (r_tsk == i_ctl.key);
    assign seen_incl = i_seen | o_match;
    assign o_seen    = seen_incl;
    assign o_link    = '{vld: r_vld, tsk: r_tsk};

    // On remove and rotate, cells at or behind the match move up one place.
    always_comb begin
        n_vld = r_vld;
        n_tsk = r_tsk;
        unique case (i_ctl.op)
            OP_NONE: begin
            end
            OP_APPEND: begin
                if (!r_vld && i_prev_vld) begin
                    n_vld = 1'b1;
                    n_tsk = i_ctl.key;
                end
            end
            OP_REMOVE: begin
                if (seen_incl) begin
                    n_vld = i_next.vld;
                    n_tsk = i_next.tsk;
                end
            end
            OP_ROTATE: begin
                // The tail cell receives the rotated task itself.
                if (seen_incl && r_vld) begin
                    n_tsk = i_next.vld ? i_next.tsk : i_ctl.key;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= i_first;
            r_tsk <= '0;
        end else begin
            r_vld <= n_vld;
            r_tsk <= n_tsk;
        end
    end

endmodule

FILE: src/rrss_queue.sv
// ----------------------------------------------------------------------------
// rrss_queue
// Ready queue built as a chain of cells, head at cell 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rrss_queue
    import rrss_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctl        i_ctl,
    output t_cell_link       o_head,
    output logic             o_found,
    output logic             o_full,
    output logic [DEPTH-1:0] o_vld
);

    t_cell_link           links [DEPTH];
    logic [DEPTH:0]       seen;
    logic [DEPTH-1:0]     match;

    assign seen[0] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_cell_link next_link;
        logic       prev_vld;

        if (g == DEPTH - 1) begin : g_tail
            assign next_link = '{vld: 1'b0, tsk: '0};
        end else begin : g_mid
            assign next_link = links[g+1];
        end

        if (g == 0) begin : g_head
            assign prev_vld = 1'b1;
        end else begin : g_body
            assign prev_vld = links[g-1].vld;
        end

        rrss_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_first    (g == 0),
            .i_ctl      (i_ctl),
            .i_seen     (seen[g]),
            .i_prev_vld (prev_vld),
            .i_next     (next_link),
            .o_link     (links[g]),
            .o_seen     (seen[g+1]),
            .o_match    (match[g])
        );

        assign o_vld[g] = links[g].vld;
    end

    assign o_head  = links[0];
    assign o_found = seen[DEPTH];
    assign o_full  = links[DEPTH-1].vld;

    `ASSERT_ON(a_single_match, i_clk, i_rst_n, $onehot0(match), "task held by two cells")
    `ASSERT_NEVER(a_gap_in_queue, i_clk, i_rst_n, (o_vld & (o_vld + DEPTH'(1))) != '0, "queue has a gap")

endmodule

FILE: src/round_robin_slice_scheduler_core.sv
// ----------------------------------------------------------------------------
// round_robin_slice_scheduler_core
// Round-robin scheduler of up to sixteen tasks with a time slice per task.
// Each request transaction (add, remove, tick, yield) yields one result
// transaction with the running task, a switch flag, an error code and the
// queue length. A request is accepted in S_IDLE, where the chain of queue
// cells searches and shifts in place; in S_DISP the queue head is dispatched
// and the result is written to the output register. S_DISP holds while that
// register is still occupied and not taken. Slice length writes are taken in
// every cycle and apply to later requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module round_robin_slice_scheduler_core
    import rrss_pkg::*;
#(
    parameter int MAX_TASKS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [SLICE_W-1:0]     i_slice_length,
    // requests
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [1:0]             i_req_type,
    input  logic [TASK_W-1:0]      i_task_id,
    // results
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [TASK_W-1:0]      o_current_task,
    output logic                   o_switched,
    output logic [1:0]             o_error_code,
    output logic [COUNT_OUT_W-1:0] o_ready_count
);

    localparam int NUM_IDS = (MAX_TASKS < TASK_IDS) ? MAX_TASKS : TASK_IDS;
    localparam int SIW     = $clog2(NUM_IDS);
    localparam int CW      = $clog2(NUM_IDS + 1);

    typedef enum logic {
        S_IDLE,
        S_DISP
    } t_state;

    t_state              r_state;
    logic [SLICE_W-1:0]  r_slice_len;
    logic [SLICE_W-1:0]  r_slice [NUM_IDS];
    logic [TASK_W-1:0]   r_run;
    logic [CW-1:0]       r_count;
    t_req                r_req;
    t_err                r_err;
    logic                r_out_vld;
    logic [TASK_W-1:0]   r_out_task;
    logic                r_out_sw;
    t_err                r_out_err;
    logic [CW-1:0]       r_out_count;

    t_req                req;
    logic                accept;
    logic                tid_ok;
    logic [SLICE_W-1:0]  slice_cur;
    logic                expire;
    t_cell_ctl           ctl;
    t_err                acc_err;
    t_cell_link          head;
    logic                found;
    logic                full;
    logic [NUM_IDS-1:0]  vld_vec;
    logic [TASK_W-1:0]   disp_run;
    logic                disp_sw;
    t_err                disp_err;

    assign req       = t_req'(i_req_type);
    assign o_ready   = (r_state == S_IDLE);
    assign accept    = i_valid && o_ready;
    assign tid_ok    = (32'(i_task_id) < 32'(NUM_IDS));
    assign slice_cur = r_slice[r_run[SIW-1:0]];
    // A counter at zero counts as expired, like one at one.
    assign expire    = (slice_cur <= 8'd1);

    assign o_cfg_ready = 1'b1;

    rrss_queue #(
        .DEPTH (NUM_IDS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .o_head  (head),
        .o_found (found),
        .o_full  (full),
        .o_vld   (vld_vec)
    );

    // Queue command of the accepted transaction.
    always_comb begin
        ctl.op  = OP_NONE;
        ctl.key = (req == REQ_ADD || req == REQ_REMOVE) ? i_task_id : r_run;
        acc_err = ERR_OK;
        if (accept) begin
            unique case (req)
                REQ_ADD: begin
                    if (!tid_ok || found || full) begin
                        acc_err = ERR_BAD;
                    end else begin
                        ctl.op = OP_APPEND;
                    end
                end
                REQ_REMOVE: begin
                    if (!tid_ok || !found) begin
                        acc_err = ERR_BAD;
                    end else begin
                        ctl.op = OP_REMOVE;
                    end
                end
                REQ_TICK: begin
                    if (expire && found) begin
                        ctl.op = OP_ROTATE;
                    end
                end
                REQ_YIELD: begin
                    if (found) begin
                        ctl.op = OP_ROTATE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Dispatch from the queue head after tick and yield.
    always_comb begin
        disp_run = r_run;
        disp_sw  = 1'b0;
        disp_err = r_err;
        if (r_req == REQ_TICK || r_req == REQ_YIELD) begin
            if (head.vld) begin
                disp_run = head.tsk;
                disp_sw  = (head.tsk != r_run);
                disp_err = ERR_OK;
            end else begin
                disp_err = ERR_EMPTY;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice_len <= SLICE_RESET;
        end else if (i_cfg_valid) begin
            r_slice_len <= i_slice_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_IDS; i++) begin
                r_slice[i] <= SLICE_RESET;
            end
        end else if (accept) begin
            if (ctl.op == OP_APPEND) begin
                r_slice[i_task_id[SIW-1:0]] <= r_slice_len;
            end else if (req == REQ_TICK) begin
                r_slice[r_run[SIW-1:0]] <= expire ? r_slice_len : slice_cur - 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_run       <= '0;
            r_count     <= CW'(1);
            r_req       <= REQ_TICK;
            r_err       <= ERR_OK;
            r_out_vld   <= 1'b0;
            r_out_task  <= '0;
            r_out_sw    <= 1'b0;
            r_out_err   <= ERR_OK;
            r_out_count <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (r_out_vld && i_ready) begin
                        r_out_vld <= 1'b0;
                    end
                    if (accept) begin
                        r_req   <= req;
                        r_err   <= acc_err;
                        r_state <= S_DISP;
                        if (ctl.op == OP_APPEND) begin
                            r_count <= r_count + CW'(1);
                        end else if (ctl.op == OP_REMOVE) begin
                            r_count <= r_count - CW'(1);
                        end
                    end
                end
                S_DISP: begin
                    // The output register is refilled in the cycle its old
                    // transaction leaves.
                    if (!r_out_vld || i_ready) begin
                        r_run       <= disp_run;
                        r_out_vld   <= 1'b1;
                        r_out_task  <= disp_run;
                        r_out_sw    <= disp_sw;
                        r_out_err   <= disp_err;
                        r_out_count <= r_count;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid        = r_out_vld;
    assign o_current_task = r_out_task;
    assign o_switched     = r_out_sw;
    assign o_error_code   = r_out_err;
    assign o_ready_count  = COUNT_OUT_W'(r_out_count);

    `ASSERT_ON(a_count_matches_cells, i_clk, i_rst_n, int'(r_count) == $countones(vld_vec), "queue count differs from valid cells")
    `ASSERT_ON(a_run_changes_on_dispatch, i_clk, i_rst_n, (r_state != S_DISP) |=> (r_run == $past(r_run)), "running task changed outside dispatch")
    `ASSERT_NEVER(a_count_range, i_clk, i_rst_n, r_count > CW'(NUM_IDS), "queue count above capacity")
    `ASSERT_NEVER(a_switch_with_error, i_clk, i_rst_n, r_out_vld && r_out_sw && (r_out_err != ERR_OK), "switch reported together with an error")

endmodule
